>>> design/lmcr_pkg.sv
package lmcr_pkg;

	// Configuration register indexes.
	typedef enum logic [3:0] {
		REG_PUSHER_STICK_THR  = 4'd0,
		REG_MAG_STICK_THR     = 4'd1,
		REG_PUSHER_FWD_LIMIT  = 4'd2,
		REG_PUSHER_BACK_LIMIT = 4'd3,
		REG_MAG_LIMIT         = 4'd4,
		REG_PUSHER_FAST       = 4'd5,
		REG_PUSHER_SLOW       = 4'd6,
		REG_MAG_SPEED         = 4'd7
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 15;
	localparam int unsigned IN_DATA_W   = 96;
	localparam int unsigned OUT_DATA_W  = 72;
	localparam int unsigned WHEEL_W     = 12;

	// Switch positions.
	localparam logic [1:0] SW_UP     = 2'd1;
	localparam logic [1:0] SW_DOWN   = 2'd2;
	localparam logic [1:0] SW_MIDDLE = 2'd3;

	// Pusher slow zones, in encoder counts.
	localparam logic signed [31:0] SLOW_ZONE_LO   = 32'sd3800;
	localparam logic signed [31:0] SLOW_ZONE_HI   = 32'sd4100;
	localparam logic signed [31:0] SLOW_ZONE_TAIL = 32'sd6900;

	// Friction wheel target for the high gear, picked by the right switch.
	function automatic logic [WHEEL_W-1:0] gear_high(input logic [1:0] rs);
		logic [WHEEL_W-1:0] v;
		unique case (rs)
			SW_UP:     v = 12'd3600;
			SW_MIDDLE: v = 12'd3590;
			SW_DOWN:   v = 12'd3580;
			default:   v = 12'd0;
		endcase
		return v;
	endfunction

	// Friction wheel target for the middle gear.
	function automatic logic [WHEEL_W-1:0] gear_mid(input logic [1:0] rs);
		logic [WHEEL_W-1:0] v;
		unique case (rs)
			SW_UP:     v = 12'd3100;
			SW_MIDDLE: v = 12'd3000;
			SW_DOWN:   v = 12'd2900;
			default:   v = 12'd0;
		endcase
		return v;
	endfunction

endpackage

>>> design/launcher_motor_command_ramp_core.sv
// Channel  | Direction | Signals                                 | Word
// ---------+-----------+-----------------------------------------+------------------------------
// s_axis   | in        | s_axis_tvalid/tready/tdata[95:0]        | one control tick
// m_axis   | out       | m_axis_tvalid/tready/tdata[71:0]        | wheel, pusher, magazine refs
// cfg      | in        | cfg_valid/ready, cfg_index[3:0],        | one register write
//          |           | cfg_data[14:0]                          |
//
// Every accepted tick sits in the input register while the compare and clamp logic works on
// it, and the result register loads the result when the input stage advances. A new word is
// accepted every cycle unless m_axis stalls; the wheel target and ramp state update as a
// word leaves the input register, so the following word already sees it.
// Reset (arst_n low) clears target and ramp to zero, empties both stages and loads
// the register defaults. A stall on m_axis holds the result and fills the input
// register before s_axis_tready drops.
module launcher_motor_command_ramp_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Fields from bit 0: left_switch[1:0], right_switch[3:2], magazine_stick[14:4],
	// pusher_stick[25:15], pusher_current[41:26], pusher_angle[73:42],
	// magazine_current[89:74], front_limit[90], rear_limit[91], zero fill[95:92].
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [lmcr_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// Fields from bit 0: left_wheel_ref[12:0], right_wheel_ref[24:13],
	// wheel_target_out[36:25], pusher_speed[52:37], magazine_speed[68:53],
	// zero fill[71:69].
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [lmcr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lmcr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lmcr_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [9:0]  pusher_stick_thr_q;
	logic [9:0]  mag_stick_thr_q;
	logic [14:0] pusher_fwd_limit_q;
	logic [14:0] pusher_back_limit_q;
	logic [14:0] mag_limit_q;
	logic [14:0] pusher_fast_q;
	logic [14:0] pusher_slow_q;
	logic [14:0] mag_speed_q;

	// Wheel state.
	logic [lmcr_pkg::WHEEL_W-1:0] wheel_target_q;
	logic [lmcr_pkg::WHEEL_W-1:0] wheel_ramp_q;

	// Input register.
	logic                                valid_s1;
	logic [lmcr_pkg::IN_DATA_W-1:0]      data_s1;

	// Result register.
	logic                                out_valid_q;
	logic [lmcr_pkg::OUT_DATA_W-1:0]     out_data_q;

	logic advance;

	// Unpacked fields of the word in the input register.
	logic [1:0]         ls;
	logic [1:0]         rs;
	logic signed [10:0] mstick;
	logic signed [10:0] pstick;
	logic signed [15:0] pcur;
	logic signed [31:0] angle;
	logic signed [15:0] mcur;
	logic               front;
	logic               rear;

	logic               run;
	logic signed [16:0] mcur_x;
	logic signed [16:0] mabs;
	logic               mag_ok;
	logic signed [11:0] mthr_pos;
	logic signed [11:0] pthr_pos;
	logic               fwd;
	logic               back;
	logic               slow_zone;
	logic signed [15:0] pusher;
	logic signed [15:0] magazine;
	logic [lmcr_pkg::WHEEL_W-1:0] target_nxt;
	logic signed [13:0] ramp_step;
	logic [lmcr_pkg::WHEEL_W-1:0] ramp_nxt;
	logic signed [12:0] left_ref;

	assign cfg_ready = 1'b1;

	// The input stage moves on whenever the result register is free or being read.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		ls     = data_s1[1:0];
		rs     = data_s1[3:2];
		mstick = $signed(data_s1[14:4]);
		pstick = $signed(data_s1[25:15]);
		pcur   = $signed(data_s1[41:26]);
		angle  = $signed(data_s1[73:42]);
		mcur   = $signed(data_s1[89:74]);
		front  = data_s1[90];
		rear   = data_s1[91];
	end

	always_comb begin
		run = (ls == lmcr_pkg::SW_UP) || (ls == lmcr_pkg::SW_MIDDLE);

		// Magazine: only drive while the current magnitude stays under its limit.
		mcur_x   = 17'(mcur);
		mabs     = mcur_x[16] ? -mcur_x : mcur_x;
		mag_ok   = mabs < $signed({2'b00, mag_limit_q});
		mthr_pos = $signed({2'b00, mag_stick_thr_q});
		magazine = '0;
		if (mag_ok && (12'(mstick) < -mthr_pos)) begin
			magazine = $signed({1'b0, mag_speed_q});
		end else if (mag_ok && (12'(mstick) > mthr_pos)) begin
			magazine = -$signed({1'b0, mag_speed_q});
		end

		// Target: a stop position clears it, a zero right switch keeps it.
		target_nxt = wheel_target_q;
		priority if (ls == lmcr_pkg::SW_UP) begin
			if (rs != 2'd0) target_nxt = lmcr_pkg::gear_high(rs);
		end else if (ls == lmcr_pkg::SW_MIDDLE) begin
			if (rs != 2'd0) target_nxt = lmcr_pkg::gear_mid(rs);
		end else begin
			target_nxt = '0;
		end

		// Pusher: forward has priority over backward.
		pthr_pos  = $signed({2'b00, pusher_stick_thr_q});
		fwd       = (12'(pstick) > pthr_pos) &&
		            (17'(pcur) > -$signed({2'b00, pusher_fwd_limit_q})) && !front;
		back      = (12'(pstick) < -pthr_pos) &&
		            (17'(pcur) < $signed({2'b00, pusher_back_limit_q})) && !rear;
		slow_zone = ((angle > lmcr_pkg::SLOW_ZONE_LO) && (angle < lmcr_pkg::SLOW_ZONE_HI)) ||
		            (angle > lmcr_pkg::SLOW_ZONE_TAIL);
		pusher    = '0;
		priority if (fwd) begin
			pusher = slow_zone ? -$signed({1'b0, pusher_slow_q})
			                   : -$signed({1'b0, pusher_fast_q});
		end else if (back) begin
			pusher = $signed({1'b0, pusher_fast_q});
		end

		// Ramp steps by one, then is clamped to the range zero to the new target.
		ramp_step = run ? $signed({2'b00, wheel_ramp_q}) + 14'sd1
		                : $signed({2'b00, wheel_ramp_q}) - 14'sd1;
		priority if (ramp_step > $signed({2'b00, target_nxt})) begin
			ramp_nxt = target_nxt;
		end else if (ramp_step < 14'sd0) begin
			ramp_nxt = '0;
		end else begin
			ramp_nxt = ramp_step[lmcr_pkg::WHEEL_W-1:0];
		end

		left_ref = -$signed({1'b0, ramp_nxt});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pusher_stick_thr_q  <= 10'd110;
			mag_stick_thr_q     <= 10'd550;
			pusher_fwd_limit_q  <= 15'd4000;
			pusher_back_limit_q <= 15'd4500;
			mag_limit_q         <= 15'd5000;
			pusher_fast_q       <= 15'd30000;
			pusher_slow_q       <= 15'd5000;
			mag_speed_q         <= 15'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lmcr_pkg::REG_PUSHER_STICK_THR:  pusher_stick_thr_q  <= cfg_data[9:0];
				lmcr_pkg::REG_MAG_STICK_THR:     mag_stick_thr_q     <= cfg_data[9:0];
				lmcr_pkg::REG_PUSHER_FWD_LIMIT:  pusher_fwd_limit_q  <= cfg_data;
				lmcr_pkg::REG_PUSHER_BACK_LIMIT: pusher_back_limit_q <= cfg_data;
				lmcr_pkg::REG_MAG_LIMIT:         mag_limit_q         <= cfg_data;
				lmcr_pkg::REG_PUSHER_FAST:       pusher_fast_q       <= cfg_data;
				lmcr_pkg::REG_PUSHER_SLOW:       pusher_slow_q       <= cfg_data;
				lmcr_pkg::REG_MAG_SPEED:         mag_speed_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			wheel_target_q <= '0;
			wheel_ramp_q   <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					wheel_target_q <= target_nxt;
					wheel_ramp_q   <= ramp_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
		if (advance && valid_s1) begin
			out_data_q <= {3'b000, magazine, pusher, target_nxt, ramp_nxt, left_ref};
		end
	end

endmodule
